FILE: rtl/aeej_pkg.sv
package aeej_pkg;

  localparam int AngW    = 16;
  localparam int LenW    = 16;
  localparam int ValW    = 26;
  localparam int ColW    = 32;
  localparam int RowW    = 3;
  localparam int NumAng  = 9;
  localparam int NumLen  = 5;
  localparam int NumCol  = 6;
  localparam int CfgIdxW = 3;
  localparam int AddrW   = 6;
  localparam int RfDepth = 64;
  localparam int SinW    = 18;
  localparam int PcW     = 8;

  localparam logic [RowW-1:0] LastRow = 3'd5;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_L2  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_L3  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_L4  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_L5  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_L11 = 3'd4;

  // Sine polynomial coefficients, Q30
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598669;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026996;
  localparam logic [30:0] SC9 = 31'd172272;

  typedef logic [NumAng-1:0][AngW-1:0] ang_set_t;
  typedef logic [NumLen-1:0][LenW-1:0] len_set_t;

  typedef struct packed {
    logic     valid;
    ang_set_t ang;
  } q_head_t;

  typedef struct packed {
    logic            start;
    logic [AngW-1:0] angle;
  } sin_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [SinW-1:0] value;
  } sin_rsp_t;

  // Angle selects of the derived angle set
  localparam logic [AddrW-1:0] AS_Q1   = 6'd0;
  localparam logic [AddrW-1:0] AS_Q2   = 6'd1;
  localparam logic [AddrW-1:0] AS_Q3   = 6'd2;
  localparam logic [AddrW-1:0] AS_Q4   = 6'd3;
  localparam logic [AddrW-1:0] AS_Q5   = 6'd4;
  localparam logic [AddrW-1:0] AS_Q23  = 6'd5;
  localparam logic [AddrW-1:0] AS_Q234 = 6'd6;
  localparam logic [AddrW-1:0] AS_QP   = 6'd7;
  localparam logic [AddrW-1:0] AS_QM   = 6'd8;

  typedef enum logic [3:0] {
    OP_CONST,
    OP_LEN,
    OP_SIN,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_HALF,
    OP_LD2,
    OP_EMIT,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    logic [AddrW-1:0] d;
  } instr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WAIT
  } seq_state_e;

  // Scratch file slots
  localparam logic [AddrW-1:0] R_Z    = 6'd0;
  localparam logic [AddrW-1:0] R_ONE  = 6'd1;
  localparam logic [AddrW-1:0] R_L2   = 6'd2;
  localparam logic [AddrW-1:0] R_L3   = 6'd3;
  localparam logic [AddrW-1:0] R_L4   = 6'd4;
  localparam logic [AddrW-1:0] R_L5   = 6'd5;
  localparam logic [AddrW-1:0] R_L11  = 6'd6;
  localparam logic [AddrW-1:0] R_D    = 6'd7;
  localparam logic [AddrW-1:0] R_S1   = 6'd8;
  localparam logic [AddrW-1:0] R_C1   = 6'd9;
  localparam logic [AddrW-1:0] R_S2   = 6'd10;
  localparam logic [AddrW-1:0] R_C2   = 6'd11;
  localparam logic [AddrW-1:0] R_S3   = 6'd12;
  localparam logic [AddrW-1:0] R_C3   = 6'd13;
  localparam logic [AddrW-1:0] R_S4   = 6'd14;
  localparam logic [AddrW-1:0] R_C4   = 6'd15;
  localparam logic [AddrW-1:0] R_S5   = 6'd16;
  localparam logic [AddrW-1:0] R_C5   = 6'd17;
  localparam logic [AddrW-1:0] R_S23  = 6'd18;
  localparam logic [AddrW-1:0] R_C23  = 6'd19;
  localparam logic [AddrW-1:0] R_S234 = 6'd20;
  localparam logic [AddrW-1:0] R_C234 = 6'd21;
  localparam logic [AddrW-1:0] R_SP   = 6'd22;
  localparam logic [AddrW-1:0] R_SM   = 6'd23;
  localparam logic [AddrW-1:0] R_T    = 6'd24;
  localparam logic [AddrW-1:0] R_T1   = 6'd25;
  localparam logic [AddrW-1:0] R_T2   = 6'd26;
  localparam logic [AddrW-1:0] R_W    = 6'd27;
  localparam logic [AddrW-1:0] R_P    = 6'd28;
  localparam logic [AddrW-1:0] R_A1   = 6'd29;
  localparam logic [AddrW-1:0] R_A2   = 6'd30;
  localparam logic [AddrW-1:0] R_A3   = 6'd31;
  localparam logic [AddrW-1:0] R_HP   = 6'd32;
  localparam logic [AddrW-1:0] R_HM   = 6'd33;
  localparam logic [AddrW-1:0] R_J00  = 6'd34;
  localparam logic [AddrW-1:0] R_J01  = 6'd35;
  localparam logic [AddrW-1:0] R_J02  = 6'd36;
  localparam logic [AddrW-1:0] R_J03  = 6'd37;
  localparam logic [AddrW-1:0] R_J04  = 6'd38;
  localparam logic [AddrW-1:0] R_J10  = 6'd39;
  localparam logic [AddrW-1:0] R_J11  = 6'd40;
  localparam logic [AddrW-1:0] R_J12  = 6'd41;
  localparam logic [AddrW-1:0] R_J13  = 6'd42;
  localparam logic [AddrW-1:0] R_J14  = 6'd43;
  localparam logic [AddrW-1:0] R_J21  = 6'd44;
  localparam logic [AddrW-1:0] R_J22  = 6'd45;
  localparam logic [AddrW-1:0] R_J23  = 6'd46;
  localparam logic [AddrW-1:0] R_J24  = 6'd47;
  localparam logic [AddrW-1:0] R_J34  = 6'd48;
  localparam logic [AddrW-1:0] R_J35  = 6'd49;
  localparam logic [AddrW-1:0] R_K0   = 6'd50;
  localparam logic [AddrW-1:0] R_NC1  = 6'd51;
  localparam logic [AddrW-1:0] R_J44  = 6'd52;
  localparam logic [AddrW-1:0] R_J45  = 6'd53;
  localparam logic [AddrW-1:0] R_J54  = 6'd54;
  localparam logic [AddrW-1:0] R_J55  = 6'd55;
  localparam logic [AddrW-1:0] R_U    = 6'd56;
  localparam logic [AddrW-1:0] R_V    = 6'd57;
  localparam logic [AddrW-1:0] R_X    = 6'd58;

  localparam logic [AddrW-1:0] NONE = 6'd0;

  function automatic instr_t mk(op_e op, logic [AddrW-1:0] a, logic [AddrW-1:0] b,
                                logic [AddrW-1:0] d);
    instr_t i;
    i.op = op;
    i.a  = a;
    i.b  = b;
    i.d  = d;
    return i;
  endfunction

  function automatic instr_t i_mul(logic [AddrW-1:0] d, logic [AddrW-1:0] a,
                                   logic [AddrW-1:0] b);
    return mk(OP_MUL, a, b, d);
  endfunction

  function automatic instr_t i_add(logic [AddrW-1:0] d, logic [AddrW-1:0] a,
                                   logic [AddrW-1:0] b);
    return mk(OP_ADD, a, b, d);
  endfunction

  function automatic instr_t i_sub(logic [AddrW-1:0] d, logic [AddrW-1:0] a,
                                   logic [AddrW-1:0] b);
    return mk(OP_SUB, a, b, d);
  endfunction

  function automatic instr_t i_half(logic [AddrW-1:0] d, logic [AddrW-1:0] a);
    return mk(OP_HALF, a, NONE, d);
  endfunction

  function automatic instr_t i_sin(logic [AddrW-1:0] d, logic [AddrW-1:0] sel,
                                   logic [AddrW-1:0] cos_sel);
    return mk(OP_SIN, sel, cos_sel, d);
  endfunction

  function automatic instr_t i_len(logic [AddrW-1:0] d, logic [AddrW-1:0] idx);
    return mk(OP_LEN, idx, NONE, d);
  endfunction

  function automatic instr_t i_const(logic [AddrW-1:0] d, logic [AddrW-1:0] k);
    return mk(OP_CONST, k, NONE, d);
  endfunction

  function automatic instr_t i_ld2(logic [AddrW-1:0] a, logic [AddrW-1:0] b,
                                   logic [AddrW-1:0] pair);
    return mk(OP_LD2, a, b, pair);
  endfunction

  function automatic instr_t i_emit(logic [AddrW-1:0] row);
    return mk(OP_EMIT, NONE, NONE, row);
  endfunction

  localparam logic [AddrW-1:0] SIN_F = 6'd0;
  localparam logic [AddrW-1:0] COS_F = 6'd1;

  localparam int ProgLen = 193;

  localparam instr_t Prog [ProgLen] = '{
    // constants and lengths
    i_const(R_Z, 6'd0), i_const(R_ONE, 6'd1),
    i_len(R_L2, 6'd0), i_len(R_L3, 6'd1), i_len(R_L4, 6'd2), i_len(R_L5, 6'd3),
    i_len(R_L11, 6'd4), i_sub(R_D, R_L5, R_L11),
    // sines and cosines
    i_sin(R_S1, AS_Q1, SIN_F), i_sin(R_C1, AS_Q1, COS_F),
    i_sin(R_S2, AS_Q2, SIN_F), i_sin(R_C2, AS_Q2, COS_F),
    i_sin(R_S3, AS_Q3, SIN_F), i_sin(R_C3, AS_Q3, COS_F),
    i_sin(R_S4, AS_Q4, SIN_F), i_sin(R_C4, AS_Q4, COS_F),
    i_sin(R_S5, AS_Q5, SIN_F), i_sin(R_C5, AS_Q5, COS_F),
    i_sin(R_S23, AS_Q23, SIN_F), i_sin(R_C23, AS_Q23, COS_F),
    i_sin(R_S234, AS_Q234, SIN_F), i_sin(R_C234, AS_Q234, COS_F),
    i_sin(R_SP, AS_QP, SIN_F), i_sin(R_SM, AS_QM, SIN_F),
    // shared terms
    i_mul(R_T, R_L4, R_S234), i_mul(R_W, R_T, R_S5),
    i_mul(R_P, R_L11, R_C234),
    i_mul(R_T1, R_L5, R_S23), i_mul(R_T2, R_L11, R_S23), i_sub(R_A1, R_T1, R_T2),
    i_mul(R_T, R_L3, R_S2), i_add(R_A1, R_A1, R_T), i_add(R_A1, R_A1, R_P),
    i_add(R_A1, R_A1, R_W),
    i_mul(R_T, R_S23, R_D), i_add(R_A2, R_T, R_P), i_add(R_A2, R_A2, R_W),
    i_add(R_A3, R_P, R_W),
    i_mul(R_T, R_L4, R_SP), i_half(R_HP, R_T), i_mul(R_T, R_L4, R_SM), i_half(R_HM, R_T),
    i_mul(R_T1, R_C1, R_C5), i_mul(R_T2, R_C234, R_S1), i_mul(R_T2, R_T2, R_S5),
    i_add(R_K0, R_T1, R_T2),
    // row 0
    i_mul(R_J00, R_L4, R_K0), i_mul(R_T, R_L2, R_C1), i_add(R_J00, R_J00, R_T),
    i_mul(R_T, R_L3, R_C2), i_mul(R_T, R_T, R_S1), i_add(R_J00, R_J00, R_T),
    i_mul(R_T, R_L11, R_S234), i_mul(R_T, R_T, R_S1), i_sub(R_J00, R_J00, R_T),
    i_mul(R_T, R_C2, R_C3), i_mul(R_T, R_T, R_S1), i_mul(R_T, R_T, R_D),
    i_add(R_J00, R_J00, R_T),
    i_mul(R_T, R_S1, R_S2), i_mul(R_T, R_T, R_S3), i_mul(R_T, R_T, R_D),
    i_sub(R_J00, R_J00, R_T),
    i_mul(R_J01, R_C1, R_A1), i_mul(R_J02, R_C1, R_A2), i_mul(R_J03, R_C1, R_A3),
    i_mul(R_T, R_L4, R_C1), i_mul(R_T, R_T, R_C2), i_mul(R_T, R_T, R_C5),
    i_mul(R_T, R_T, R_S3), i_mul(R_J04, R_T, R_S4),
    i_mul(R_T, R_L4, R_C1), i_mul(R_T, R_T, R_C2), i_mul(R_T, R_T, R_C3),
    i_mul(R_T, R_T, R_C4), i_mul(R_T, R_T, R_C5), i_sub(R_J04, R_J04, R_T),
    i_mul(R_T, R_L4, R_S1), i_mul(R_T, R_T, R_S5), i_sub(R_J04, R_J04, R_T),
    i_mul(R_T, R_L4, R_C1), i_mul(R_T, R_T, R_C3), i_mul(R_T, R_T, R_C5),
    i_mul(R_T, R_T, R_S2), i_mul(R_T, R_T, R_S4), i_add(R_J04, R_J04, R_T),
    i_mul(R_T, R_L4, R_C1), i_mul(R_T, R_T, R_C4), i_mul(R_T, R_T, R_C5),
    i_mul(R_T, R_T, R_S2), i_mul(R_T, R_T, R_S3), i_add(R_J04, R_J04, R_T),
    // row 1
    i_mul(R_T1, R_C5, R_S1), i_mul(R_T2, R_C234, R_C1), i_mul(R_T2, R_T2, R_S5),
    i_sub(R_J35, R_T1, R_T2),
    i_mul(R_J10, R_L4, R_J35), i_mul(R_T, R_L2, R_S1), i_add(R_J10, R_J10, R_T),
    i_mul(R_T, R_L3, R_C1), i_mul(R_T, R_T, R_C2), i_sub(R_J10, R_J10, R_T),
    i_mul(R_X, R_L11, R_S234), i_mul(R_T, R_X, R_C1), i_add(R_J10, R_J10, R_T),
    i_mul(R_T, R_C1, R_C2), i_mul(R_T, R_T, R_C3), i_mul(R_T, R_T, R_D),
    i_sub(R_J10, R_J10, R_T),
    i_mul(R_T, R_C1, R_S2), i_mul(R_T, R_T, R_S3), i_mul(R_T, R_T, R_D),
    i_add(R_J10, R_J10, R_T),
    i_mul(R_J11, R_S1, R_A1), i_mul(R_J12, R_S1, R_A2), i_mul(R_J13, R_S1, R_A3),
    i_mul(R_T, R_L4, R_C1), i_mul(R_J14, R_T, R_S5),
    i_mul(R_T, R_L4, R_C2), i_mul(R_T, R_T, R_C5), i_mul(R_T, R_T, R_S1),
    i_mul(R_T, R_T, R_S3), i_mul(R_T, R_T, R_S4), i_add(R_J14, R_J14, R_T),
    i_mul(R_T, R_L4, R_C3), i_mul(R_T, R_T, R_C5), i_mul(R_T, R_T, R_S1),
    i_mul(R_T, R_T, R_S2), i_mul(R_T, R_T, R_S4), i_add(R_J14, R_J14, R_T),
    i_mul(R_T, R_L4, R_C4), i_mul(R_T, R_T, R_C5), i_mul(R_T, R_T, R_S1),
    i_mul(R_T, R_T, R_S2), i_mul(R_T, R_T, R_S3), i_add(R_J14, R_J14, R_T),
    i_mul(R_T, R_L4, R_C2), i_mul(R_T, R_T, R_C3), i_mul(R_T, R_T, R_C4),
    i_mul(R_T, R_T, R_C5), i_mul(R_T, R_T, R_S1), i_sub(R_J14, R_J14, R_T),
    // row 2
    i_mul(R_U, R_L11, R_C23), i_mul(R_V, R_L5, R_C23), i_sub(R_J21, R_U, R_V),
    i_sub(R_J21, R_J21, R_HP), i_mul(R_T, R_L3, R_C2), i_sub(R_J21, R_J21, R_T),
    i_add(R_J21, R_J21, R_HM), i_add(R_J21, R_J21, R_X),
    i_sub(R_J22, R_U, R_V), i_sub(R_J22, R_J22, R_HP), i_add(R_J22, R_J22, R_HM),
    i_add(R_J22, R_J22, R_X),
    i_sub(R_J23, R_HM, R_HP), i_add(R_J23, R_J23, R_X),
    i_half(R_T1, R_SP), i_half(R_T2, R_SM), i_add(R_T1, R_T1, R_T2),
    i_mul(R_T, R_L4, R_T1), i_sub(R_J24, R_Z, R_T),
    // rows 3 to 5
    i_mul(R_J34, R_S234, R_C1), i_sub(R_NC1, R_Z, R_C1), i_mul(R_J44, R_S234, R_S1),
    i_sub(R_J45, R_Z, R_K0), i_sub(R_J54, R_Z, R_C234), i_mul(R_T, R_S234, R_S5),
    i_sub(R_J55, R_Z, R_T),
    // row delivery
    i_ld2(R_J00, R_J01, 6'd0), i_ld2(R_J02, R_J03, 6'd1), i_ld2(R_J04, R_Z, 6'd2),
    i_emit(6'd0),
    i_ld2(R_J10, R_J11, 6'd0), i_ld2(R_J12, R_J13, 6'd1), i_ld2(R_J14, R_Z, 6'd2),
    i_emit(6'd1),
    i_ld2(R_Z, R_J21, 6'd0), i_ld2(R_J22, R_J23, 6'd1), i_ld2(R_J24, R_Z, 6'd2),
    i_emit(6'd2),
    i_ld2(R_Z, R_S1, 6'd0), i_ld2(R_S1, R_S1, 6'd1), i_ld2(R_J34, R_J35, 6'd2),
    i_emit(6'd3),
    i_ld2(R_Z, R_NC1, 6'd0), i_ld2(R_NC1, R_NC1, 6'd1), i_ld2(R_J44, R_J45, 6'd2),
    i_emit(6'd4),
    i_ld2(R_ONE, R_Z, 6'd0), i_ld2(R_Z, R_Z, 6'd1), i_ld2(R_J54, R_J55, 6'd2),
    i_emit(6'd5),
    mk(OP_DONE, NONE, NONE, NONE)
  };

endpackage

FILE: rtl/aeej_front.sv
module aeej_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [aeej_pkg::AngW-1:0]         q1_i,
  input  logic [aeej_pkg::AngW-1:0]         q2_i,
  input  logic [aeej_pkg::AngW-1:0]         q3_i,
  input  logic [aeej_pkg::AngW-1:0]         q4_i,
  input  logic [aeej_pkg::AngW-1:0]         q5_i,
  output aeej_pkg::q_head_t                 head_o,
  input  logic                              pop_i
);

  aeej_pkg::ang_set_t mem_q [2];
  aeej_pkg::ang_set_t ang_set;
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q;
  logic               push;
  logic [aeej_pkg::AngW-1:0] q23, q234;

  // Derive the summed joint angles once, on entry; all wrap mod a full turn
  always_comb begin
    q23  = q2_i + q3_i;
    q234 = q23 + q4_i;
    ang_set[0] = q1_i;
    ang_set[1] = q2_i;
    ang_set[2] = q3_i;
    ang_set[3] = q4_i;
    ang_set[4] = q5_i;
    ang_set[5] = q23;
    ang_set[6] = q234;
    ang_set[7] = q234 + q5_i;
    ang_set[8] = q234 - q5_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.ang   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ang_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

FILE: rtl/aeej_sine.sv
module aeej_sine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aeej_pkg::sin_req_t req_i,
  output aeej_pkg::sin_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [2:0]  step_q;
  logic [1:0]  quad_q;
  logic [16:0] t_q, t2_q;
  logic [30:0] p_q;
  logic signed [aeej_pkg::SinW-1:0] val_q;

  logic [13:0] x;
  logic [14:0] xm;
  logic [16:0] t_start;
  logic [30:0] mul_a;
  logic [16:0] mul_b;
  logic [47:0] prod;
  logic [31:0] hi;
  logic [30:0] coef;
  logic [32:0] rsum;
  logic [18:0] rnd;
  logic [16:0] mag;

  always_comb begin
    x       = req_i.angle[13:0];
    xm      = req_i.angle[14] ? 15'(15'd16384 - {1'b0, x}) : {1'b0, x};
    t_start = {xm, 2'b00};
    mul_a   = (step_q == 3'd0) ? {14'd0, t_q} : p_q;
    mul_b   = (step_q == 3'd0 || step_q == 3'd5) ? t_q : t2_q;
    prod    = 48'(mul_a) * 48'(mul_b);
    hi      = prod[47:16];
    case (step_q)
      3'd1:    coef = aeej_pkg::SC7;
      3'd2:    coef = aeej_pkg::SC5;
      3'd3:    coef = aeej_pkg::SC3;
      default: coef = aeej_pkg::SC1;
    endcase
    rsum = {1'b0, hi} + 33'd8192;
    rnd  = rsum[32:14];
    mag  = (rnd > 19'd65536) ? 17'd65536 : rnd[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quad_q <= req_i.angle[15:14];
      t_q    <= t_start;
    end else if (busy_q) begin
      case (step_q)
        3'd0: begin
          t2_q <= hi[16:0];
          p_q  <= aeej_pkg::SC9;
        end
        3'd5: begin
          val_q <= quad_q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        default: begin
          p_q <= 31'(coef - hi[30:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = val_q;

endmodule

FILE: rtl/aeej_back.sv
module aeej_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  aeej_pkg::q_head_t                      head_i,
  output logic                                   pop_o,
  input  aeej_pkg::len_set_t                     lens_i,
  output aeej_pkg::sin_req_t                     sin_req_o,
  input  aeej_pkg::sin_rsp_t                     sin_rsp_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [aeej_pkg::RowW-1:0]              row_o,
  output logic [aeej_pkg::NumCol-1:0][aeej_pkg::ColW-1:0] cols_o,
  output logic                                   last_o
);

  aeej_pkg::seq_state_e state_q, state_d;
  logic [aeej_pkg::PcW-1:0] pc_q, pc_d;
  aeej_pkg::instr_t ins;

  logic signed [aeej_pkg::ValW-1:0] rf [aeej_pkg::RfDepth];
  logic signed [aeej_pkg::ValW-1:0] ra_q, rb_q;
  logic signed [aeej_pkg::ValW-1:0] build_q [aeej_pkg::NumCol];

  logic        we, build_we, out_load, out_free;
  logic signed [aeej_pkg::ValW-1:0] wd, alu;
  logic signed [2*aeej_pkg::ValW-1:0] prod, prnd;
  logic signed [aeej_pkg::ValW:0] hsum;
  logic [aeej_pkg::LenW-1:0] len_sel;

  logic out_valid_q, last_q;
  logic [aeej_pkg::RowW-1:0] row_q;
  logic [aeej_pkg::NumCol-1:0][aeej_pkg::ColW-1:0] cols_q;

  assign ins      = aeej_pkg::Prog[pc_q];
  assign out_free = !out_valid_q || out_ready_i;

  // Datapath
  always_comb begin
    prod    = $signed(ra_q) * $signed(rb_q);
    prnd    = (prod + (2*aeej_pkg::ValW)'(32768)) >>> 16;
    hsum    = ({ra_q[aeej_pkg::ValW-1], ra_q} + (aeej_pkg::ValW+1)'(1)) >>> 1;
    len_sel = lens_i[ins.a[2:0]];
    case (ins.op)
      aeej_pkg::OP_CONST: alu = ins.a[0] ? aeej_pkg::ValW'(65536) : '0;
      aeej_pkg::OP_LEN:   alu = $signed({{(aeej_pkg::ValW-aeej_pkg::LenW-2){1'b0}},
                                         len_sel, 2'b00});
      aeej_pkg::OP_MUL:   alu = prnd[aeej_pkg::ValW-1:0];
      aeej_pkg::OP_ADD:   alu = ra_q + rb_q;
      aeej_pkg::OP_SUB:   alu = ra_q - rb_q;
      aeej_pkg::OP_HALF:  alu = hsum[aeej_pkg::ValW-1:0];
      default:            alu = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aeej_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          state_d = aeej_pkg::ST_READ;
        end
      end
      aeej_pkg::ST_READ: state_d = aeej_pkg::ST_EXEC;
      aeej_pkg::ST_EXEC: begin
        case (ins.op)
          aeej_pkg::OP_SIN:  state_d = aeej_pkg::ST_WAIT;
          aeej_pkg::OP_EMIT: state_d = out_free ? aeej_pkg::ST_READ : aeej_pkg::ST_EXEC;
          aeej_pkg::OP_DONE: state_d = aeej_pkg::ST_IDLE;
          default:           state_d = aeej_pkg::ST_READ;
        endcase
      end
      aeej_pkg::ST_WAIT: begin
        if (sin_rsp_i.done) begin
          state_d = aeej_pkg::ST_READ;
        end
      end
      default: state_d = aeej_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pc_d            = pc_q;
    we              = 1'b0;
    wd              = alu;
    build_we        = 1'b0;
    out_load        = 1'b0;
    pop_o           = 1'b0;
    sin_req_o.start = 1'b0;
    sin_req_o.angle = head_i.ang[ins.a[3:0]] + (ins.b[0] ? 16'd16384 : 16'd0);
    case (state_q)
      aeej_pkg::ST_EXEC: begin
        case (ins.op)
          aeej_pkg::OP_SIN: sin_req_o.start = 1'b1;
          aeej_pkg::OP_EMIT: begin
            if (out_free) begin
              out_load = 1'b1;
              pc_d     = pc_q + 1'b1;
            end
          end
          aeej_pkg::OP_DONE: begin
            pop_o = 1'b1;
            pc_d  = '0;
          end
          aeej_pkg::OP_LD2: begin
            build_we = 1'b1;
            pc_d     = pc_q + 1'b1;
          end
          default: begin
            we   = 1'b1;
            pc_d = pc_q + 1'b1;
          end
        endcase
      end
      aeej_pkg::ST_WAIT: begin
        if (sin_rsp_i.done) begin
          we   = 1'b1;
          wd   = aeej_pkg::ValW'(sin_rsp_i.value);
          pc_d = pc_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rf[ins.d] <= wd;
    end
    if (state_q == aeej_pkg::ST_READ) begin
      ra_q <= rf[ins.a];
      rb_q <= rf[ins.b];
    end
    if (build_we) begin
      build_q[{ins.d[1:0], 1'b0}] <= ra_q;
      build_q[{ins.d[1:0], 1'b1}] <= rb_q;
    end
    if (out_load) begin
      row_q  <= ins.d[aeej_pkg::RowW-1:0];
      last_q <= (ins.d[aeej_pkg::RowW-1:0] == aeej_pkg::LastRow);
      for (int c = 0; c < aeej_pkg::NumCol; c++) begin
        cols_q[c] <= aeej_pkg::ColW'(build_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aeej_pkg::ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign cols_o      = cols_q;
  assign last_o      = last_q;

endmodule

FILE: rtl/arm_end_effector_jacobian.sv
// End-effector geometric Jacobian of a six-axis arm. Each beat on the input
// channel carries five joint angles (binary angles, a full turn is 65536) and
// produces six output beats, Jacobian rows 0 to 5 in order (rows 0-2 linear,
// rows 3-5 angular), each with six signed Q15.16 entries and last_row set on
// row 5. Link lengths L2, L3, L4, L5 and L11 (unsigned Q2.14 metres, reset 0)
// are written over the configuration channel at indexes 0 to 4; a write to a
// higher index is taken and dropped. Write them only while the block is idle.
// An input beat is taken into a two-entry angle queue; the set being worked on
// stays at its head until its last row is issued, so one more set can wait
// behind it. The back end runs a fixed 193-step program on one shared
// multiply/add unit and a 64-entry scratch file: each arithmetic step is
// read, then executed, and each of the sixteen sine/cosine evaluations
// waits on the iterative polynomial unit, so the back end works on one
// angle set at a time on that single datapath.
// The six rows leave through an output register that holds a row while the
// sink stalls.
module arm_end_effector_jacobian (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aeej_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [aeej_pkg::LenW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [aeej_pkg::AngW-1:0]           angle_base_i,
  input  logic [aeej_pkg::AngW-1:0]           angle_shoulder_i,
  input  logic [aeej_pkg::AngW-1:0]           angle_elbow_i,
  input  logic [aeej_pkg::AngW-1:0]           angle_wrist_one_i,
  input  logic [aeej_pkg::AngW-1:0]           angle_wrist_two_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [aeej_pkg::RowW-1:0]           row_index_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_zero_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_one_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_two_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_three_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_four_o,
  output logic signed [aeej_pkg::ColW-1:0]    col_five_o,
  output logic                                last_row_o
);

  aeej_pkg::len_set_t len_q;
  aeej_pkg::q_head_t  head;
  aeej_pkg::sin_req_t sin_req;
  aeej_pkg::sin_rsp_t sin_rsp;
  logic               pop;
  logic [aeej_pkg::NumCol-1:0][aeej_pkg::ColW-1:0] cols;

  // Configuration registers: always ready, drop writes past the last length
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aeej_pkg::CFG_L2:  len_q[0] <= cfg_data_i;
        aeej_pkg::CFG_L3:  len_q[1] <= cfg_data_i;
        aeej_pkg::CFG_L4:  len_q[2] <= cfg_data_i;
        aeej_pkg::CFG_L5:  len_q[3] <= cfg_data_i;
        aeej_pkg::CFG_L11: len_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: accept a beat, derive summed angles, queue the set
  aeej_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q1_i       (angle_base_i),
    .q2_i       (angle_shoulder_i),
    .q3_i       (angle_elbow_i),
    .q4_i       (angle_wrist_one_i),
    .q5_i       (angle_wrist_two_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Sine unit shared by all sixteen trig evaluations of an angle set
  aeej_sine u_sine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sin_req),
    .rsp_o  (sin_rsp)
  );

  // Back end: program sequencer, scratch file and output register
  aeej_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .lens_i      (len_q),
    .sin_req_o   (sin_req),
    .sin_rsp_i   (sin_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_o       (row_index_o),
    .cols_o      (cols),
    .last_o      (last_row_o)
  );

  assign col_zero_o  = cols[0];
  assign col_one_o   = cols[1];
  assign col_two_o   = cols[2];
  assign col_three_o = cols[3];
  assign col_four_o  = cols[4];
  assign col_five_o  = cols[5];

endmodule

FILE: rtl/aeej_checker.sv
module aeej_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [aeej_pkg::RowW-1:0]         row_index_o,
  input logic signed [aeej_pkg::ColW-1:0]  col_zero_o,
  input logic signed [aeej_pkg::ColW-1:0]  col_one_o,
  input logic signed [aeej_pkg::ColW-1:0]  col_two_o,
  input logic signed [aeej_pkg::ColW-1:0]  col_three_o,
  input logic                              last_row_o
);

  // A stalled output beat holds its row
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o))
    else $error("output beat changed while stalled");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == aeej_pkg::LastRow)))
    else $error("last_row does not match row 5");

  a_row5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_row_o |-> col_zero_o == 32'sd65536 && col_one_o == 32'sd0
      && col_two_o == 32'sd0 && col_three_o == 32'sd0)
    else $error("row 5 fixed entries wrong");

  a_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_index_o == 3'd3 |-> col_zero_o == 32'sd0
      && col_one_o == col_two_o && col_two_o == col_three_o)
    else $error("row 3 repeated entries differ");

endmodule

bind arm_end_effector_jacobian aeej_checker u_aeej_checker (.*);
